### design/lgm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lgm_pkg
// Shared types and constants for the luminance gradient map.
// ----------------------------------------------------------------------------
package lgm_pkg;

  localparam int DEF_MAX_STOPS = 4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 40;
  localparam int POS_W      = 16;
  localparam int COLOR_W    = 24;
  localparam int T_W        = 17;

  localparam logic [CFG_IDX_W-1:0] CFG_COUNT      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_FIRST = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLEND      = 3'd5;

  localparam logic [13:0] LUM_R = 14'd13933;
  localparam logic [15:0] LUM_G = 16'd46871;
  localparam logic [12:0] LUM_B = 13'd4732;

  localparam logic [2:0]            RST_COUNT = 3'd2;
  localparam logic [CFG_DATA_W-1:0] RST_STOP1 = 40'hFF00FFFFFF;
  localparam logic [8:0]            RST_BLEND = 9'd256;

  typedef struct packed {
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
  } result_t;

  typedef struct packed {
    pixel_t               pix;
    logic [COLOR_W-1:0]   ca;
    logic [COLOR_W-1:0]   cb;
  } carry_t;

endpackage

### design/luminance_gradient_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// luminance_gradient_map
// Maps pixel luminance through a piecewise-linear color gradient and blends.
//
// channel  ports                        direction  word
// input    in_valid in_stall in_pixel   in         one RGB pixel
// output   out_valid out_stall out_pixel out       one RGB pixel
// config   cfg_we cfg_index cfg_data    in         one register write
//
// One pixel enters per clock while in_stall is low; stages are luminance,
// stop search, a 17-stage restoring divider for the Q16 segment fraction,
// color mix, blend. The divider stages set the depth. The whole pipeline
// advances unless a result is held on a stalled output. Synchronous reset
// clears the valid bits and loads the default registers.
// ----------------------------------------------------------------------------
module luminance_gradient_map
  import lgm_pkg::*;
#(
  parameter int MAX_STOPS = DEF_MAX_STOPS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  pixel_t                in_pixel,
  output logic                  out_valid,
  input  logic                  out_stall,
  output result_t               out_pixel,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = $clog2(MAX_STOPS);
  localparam int DIV_N = T_W;

  logic [2:0]            count_r;
  logic [CFG_DATA_W-1:0] stop_r [MAX_STOPS];
  logic [8:0]            blend_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= RST_COUNT;
      blend_r <= RST_BLEND;
    end else if (cfg_we) begin
      if (cfg_index == CFG_COUNT) count_r <= cfg_data[2:0];
      if (cfg_index == CFG_BLEND) blend_r <= cfg_data[8:0];
    end
  end

  for (genvar i = 0; i < MAX_STOPS; i++) begin : g_stop
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        stop_r[i] <= (i == 1) ? RST_STOP1 : '0;
      end else if (cfg_we && cfg_index == CFG_STOP_FIRST + CFG_IDX_W'(i)) begin
        stop_r[i] <= cfg_data;
      end
    end
  end

  logic        out_valid_r;
  result_t     out_pixel_r;

  logic adv;
  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  // stage 1: luminance
  logic          v1_r;
  logic [15:0]   lum_r;
  pixel_t        pix1_r;
  logic [23:0]   lum_sum;

  assign lum_sum = 24'(LUM_R * in_pixel.pixel_red) + 24'(LUM_G * in_pixel.pixel_green)
                 + 24'(LUM_B * in_pixel.pixel_blue);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      lum_r  <= lum_sum[23:8];
      pix1_r <= in_pixel;
    end
  end

  // stage 2: stop search
  logic [2:0]         n_eff;
  logic [IDX_W-1:0]   last;
  logic [POS_W-1:0]   pos [MAX_STOPS];
  logic [COLOR_W-1:0] col [MAX_STOPS];
  logic [COLOR_W-1:0] sel_a, sel_b;
  logic [POS_W-1:0]   sel_d, sel_den;

  always_comb begin
    if (count_r == 3'd0) begin
      n_eff = 3'd1;
    end else if (32'(count_r) > MAX_STOPS) begin
      n_eff = 3'(MAX_STOPS);
    end else begin
      n_eff = count_r;
    end
  end

  assign last = IDX_W'(n_eff - 3'd1);

  for (genvar i = 0; i < MAX_STOPS; i++) begin : g_unpack
    assign pos[i] = stop_r[i][39:24];
    assign col[i] = stop_r[i][23:0];
  end

  always_comb begin
    sel_a   = '0;
    sel_b   = '0;
    sel_d   = '0;
    sel_den = 16'd1;
    for (int i = MAX_STOPS - 2; i >= 0; i--) begin
      if ((i + 1) < int'(n_eff) && lum_r >= pos[i] && lum_r <= pos[i+1]) begin
        sel_a = col[i];
        if (pos[i+1] == pos[i]) begin
          sel_b   = col[i];
          sel_d   = '0;
          sel_den = 16'd1;
        end else begin
          sel_b   = col[i+1];
          sel_d   = lum_r - pos[i];
          sel_den = pos[i+1] - pos[i];
        end
      end
    end
    if (lum_r >= pos[last]) begin
      sel_a = col[last];
      sel_b = col[last];
    end
    if (lum_r <= pos[0]) begin
      sel_a = col[0];
      sel_b = col[0];
    end
  end

  logic             v2_r;
  carry_t           c2_r;
  logic [POS_W-1:0] d2_r, den2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c2_r   <= '{pix: pix1_r, ca: sel_a, cb: sel_b};
      d2_r   <= sel_d;
      den2_r <= sel_den;
    end
  end

  // divider stages: one quotient bit each
  logic             dv_r   [DIV_N];
  carry_t           dc_r   [DIV_N];
  logic [T_W-1:0]   drem_r [DIV_N];
  logic [T_W-1:0]   dq_r   [DIV_N];
  logic [POS_W-1:0] dden_r [DIV_N];

  for (genvar j = 0; j < DIV_N; j++) begin : g_div
    logic             v_in;
    carry_t           c_in;
    logic [T_W-1:0]   r_in, q_in, r_nxt;
    logic [POS_W-1:0] den_in;
    logic             bit_nxt;

    if (j == 0) begin : g_first
      assign v_in   = v2_r;
      assign c_in   = c2_r;
      assign r_in   = T_W'(d2_r);
      assign q_in   = '0;
      assign den_in = den2_r;
    end else begin : g_next
      assign v_in   = dv_r[j-1];
      assign c_in   = dc_r[j-1];
      assign r_in   = {drem_r[j-1][T_W-2:0], 1'b0};
      assign q_in   = dq_r[j-1];
      assign den_in = dden_r[j-1];
    end

    assign bit_nxt = r_in >= T_W'(den_in);
    assign r_nxt   = bit_nxt ? r_in - T_W'(den_in) : r_in;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[j] <= 1'b0;
      end else if (adv) begin
        dv_r[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dc_r[j]   <= c_in;
        drem_r[j] <= r_nxt;
        dq_r[j]   <= {q_in[T_W-2:0], bit_nxt};
        dden_r[j] <= den_in;
      end
    end
  end

  // mix stage
  logic           vm_r;
  pixel_t         pixm_r;
  logic [23:0]    grad_r;
  logic [23:0]    grad_nxt;
  logic [T_W-1:0] t_fin, t_inv;

  assign t_fin = dq_r[DIV_N-1];
  assign t_inv = T_W'(18'd65536 - {1'b0, t_fin});

  for (genvar c = 0; c < 3; c++) begin : g_mix
    logic [7:0]  ch_a, ch_b;
    logic [24:0] mix;
    assign ch_a = dc_r[DIV_N-1].ca[8*c +: 8];
    assign ch_b = dc_r[DIV_N-1].cb[8*c +: 8];
    assign mix  = 25'(ch_a * t_inv) + 25'(ch_b * t_fin);
    assign grad_nxt[8*c +: 8] = mix[23:16];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vm_r <= 1'b0;
    end else if (adv) begin
      vm_r <= dv_r[DIV_N-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      grad_r <= grad_nxt;
      pixm_r <= dc_r[DIV_N-1].pix;
    end
  end

  // blend stage
  logic [23:0] orig;
  logic [23:0] blend_nxt;
  logic        do_blend;
  logic [8:0]  k_inv;

  assign orig     = pixm_r;
  assign do_blend = blend_r >= 9'd1 && blend_r <= 9'd255;
  assign k_inv    = 9'd256 - blend_r;

  for (genvar c = 0; c < 3; c++) begin : g_blend
    logic [16:0] sum;
    assign sum = 17'(orig[8*c +: 8] * k_inv) + 17'(grad_r[8*c +: 8] * blend_r);
    assign blend_nxt[8*c +: 8] = do_blend ? sum[15:8] : grad_r[8*c +: 8];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pixel_r <= blend_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;

  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    dv_r[DIV_N-1] |-> drem_r[DIV_N-1] < T_W'(dden_r[DIV_N-1]))
    else $error("divider remainder not below divisor");

  a_t_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    dv_r[DIV_N-1] |-> (!t_fin[T_W-1] || t_fin[T_W-2:0] == '0))
    else $error("segment fraction above one");

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !v1_r)
    else $error("valid bits not cleared by reset");

endmodule

### sim/luminance_gradient_map_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// luminance_gradient_map_tb
// Self-checking bench for the luminance gradient map. A clocked driver sends
// pixel words from a queue and a clocked monitor compares each result word
// against a colorize-and-blend predictor. Gradient settings change between
// phases while the pipeline is empty. Sender gaps and receiver stalls are
// varied from phase to phase.
// ----------------------------------------------------------------------------
module luminance_gradient_map_tb;
  import lgm_pkg::*;

  localparam int N_STOPS   = 4;
  localparam int LATENCY   = 21;
  localparam int MAX_CYCLE = 400000;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  pixel_t                in_pixel = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  result_t               out_pixel;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pixel_t  pixel_q[$];
  result_t colored_q[$];
  int      error_count = 0;
  int      cycle_count = 0;
  int      send_idle_pct = 0;
  int      stall_pct = 0;
  logic    driver_ready = 1'b0;

  logic [2:0]  g_count;
  logic [39:0] g_stop[N_STOPS];
  logic [8:0]  g_blend;

  luminance_gradient_map dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= MAX_CYCLE) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  function automatic logic [15:0] stop_pos(logic [39:0] s);
    return s[39:24];
  endfunction

  function automatic logic [7:0] stop_chan(logic [39:0] s, int ch);
    return s[16 - 8 * ch +: 8];
  endfunction

  function automatic result_t colorize(pixel_t p);
    logic [7:0]  orig[3];
    logic [7:0]  col[3];
    logic [31:0] lum;
    logic [63:0] t;
    logic [63:0] v;
    logic [31:0] bv;
    int          n;
    bit          found;
    logic [15:0] pa, pb;
    result_t     r;
    orig[0] = p.pixel_red;
    orig[1] = p.pixel_green;
    orig[2] = p.pixel_blue;
    lum = (32'd13933 * orig[0] + 32'd46871 * orig[1] + 32'd4732 * orig[2]) >> 8;
    n = g_count;
    if (n == 0) n = 1;
    if (n > N_STOPS) n = N_STOPS;
    found = 1'b0;
    for (int ch = 0; ch < 3; ch++) col[ch] = 8'd0;
    if (lum <= stop_pos(g_stop[0])) begin
      for (int ch = 0; ch < 3; ch++) col[ch] = stop_chan(g_stop[0], ch);
    end else if (lum >= stop_pos(g_stop[n-1])) begin
      for (int ch = 0; ch < 3; ch++) col[ch] = stop_chan(g_stop[n-1], ch);
    end else begin
      for (int i = 0; i + 1 < n; i++) begin
        pa = stop_pos(g_stop[i]);
        pb = stop_pos(g_stop[i+1]);
        if (!found && lum >= pa && lum <= pb) begin
          found = 1'b1;
          t = 0;
          if (pb != pa) t = (64'(lum - pa) << 16) / 64'(pb - pa);
          for (int ch = 0; ch < 3; ch++) begin
            v = 64'(stop_chan(g_stop[i], ch)) * (64'd65536 - t)
              + 64'(stop_chan(g_stop[i+1], ch)) * t;
            col[ch] = v[23:16];
          end
        end
      end
    end
    for (int ch = 0; ch < 3; ch++) begin
      bv = col[ch];
      if (g_blend >= 1 && g_blend <= 255)
        bv = (32'(orig[ch]) * (32'd256 - g_blend) + 32'(col[ch]) * g_blend) >> 8;
      col[ch] = bv[7:0];
    end
    r.out_red = col[0];
    r.out_green = col[1];
    r.out_blue = col[2];
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      colored_q.push_back(colorize(in_pixel));
    end
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && in_stall)) begin
      if (driver_ready && pixel_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_pixel <= pixel_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (colored_q.size() == 0) begin
        report_mismatch("unexpected word", int'(out_pixel), 0);
      end else begin
        want = colored_q.pop_front();
        if (out_pixel.out_red != want.out_red)
          report_mismatch("red", out_pixel.out_red, want.out_red);
        if (out_pixel.out_green != want.out_green)
          report_mismatch("green", out_pixel.out_green, want.out_green);
        if (out_pixel.out_blue != want.out_blue)
          report_mismatch("blue", out_pixel.out_blue, want.out_blue);
      end
    end
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_COUNT) g_count = val[2:0];
    else if (idx >= CFG_STOP_FIRST && idx < CFG_BLEND) g_stop[idx - CFG_STOP_FIRST] = val;
    else if (idx == CFG_BLEND) g_blend = val[8:0];
  endtask

  task automatic drain;
    driver_ready = 1'b0;
    @(posedge clk);
    while (colored_q.size() > 0 || in_valid) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic run_pixels(int count);
    pixel_t p;
    for (int i = 0; i < count; i++) begin
      p = 24'($urandom);
      pixel_q.push_back(p);
    end
    driver_ready = 1'b1;
    while (pixel_q.size() > 0) @(posedge clk);
    drain();
  endtask

  function automatic logic [39:0] mk_stop(logic [15:0] pos);
    logic [23:0] c;
    c = 24'($urandom);
    return {pos, c};
  endfunction

  task automatic random_gradient;
    logic [15:0] pos[N_STOPS];
    for (int i = 0; i < N_STOPS; i++) pos[i] = 16'($urandom_range(65280));
    pos.sort();
    if ($urandom_range(5) == 0) pos[1] = pos[0];
    if ($urandom_range(5) == 0) pos[2] = 16'($urandom_range(0, pos[1]));
    if ($urandom_range(9) == 0) pos[3] = 16'hFFFF;
    write_reg(CFG_COUNT, CFG_DATA_W'($urandom_range(7)));
    for (int i = 0; i < N_STOPS; i++)
      write_reg(CFG_STOP_FIRST + CFG_IDX_W'(i), mk_stop(pos[i]));
    case ($urandom_range(3))
      0: write_reg(CFG_BLEND, CFG_DATA_W'($urandom_range(1, 255)));
      1: write_reg(CFG_BLEND, CFG_DATA_W'($urandom_range(257, 511)));
      2: write_reg(CFG_BLEND, '0);
      default: write_reg(CFG_BLEND, 40'd256);
    endcase
  endtask

  initial begin
    pixel_t dp;
    g_count = RST_COUNT;
    foreach (g_stop[i]) g_stop[i] = '0;
    g_stop[1] = RST_STOP1;
    g_blend = RST_BLEND;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    pixel_q.push_back(24'h000000);
    pixel_q.push_back(24'hFFFFFF);
    pixel_q.push_back(24'hFF0000);
    pixel_q.push_back(24'h00FF00);
    pixel_q.push_back(24'h0000FF);
    pixel_q.push_back(24'h808080);
    pixel_q.push_back(24'h55AA55);
    pixel_q.push_back(24'hAA55AA);
    driver_ready = 1'b1;
    while (pixel_q.size() > 0) @(posedge clk);
    drain();

    write_reg(CFG_COUNT, 40'd4);
    write_reg(CFG_STOP_FIRST + 3'd0, {16'd10000, 24'hFF0000});
    write_reg(CFG_STOP_FIRST + 3'd1, {16'd30000, 24'h00FF00});
    write_reg(CFG_STOP_FIRST + 3'd2, {16'd30000, 24'h0000FF});
    write_reg(CFG_STOP_FIRST + 3'd3, {16'd65280, 24'hFFFFFF});
    write_reg(CFG_BLEND, 40'd1);
    for (int v = 0; v < 256; v += 17) begin
      dp = {v[7:0], v[7:0], v[7:0]};
      pixel_q.push_back(dp);
    end
    driver_ready = 1'b1;
    while (pixel_q.size() > 0) @(posedge clk);
    drain();

    write_reg(CFG_STOP_FIRST + 3'd1, {16'd5000, 24'h123456});
    write_reg(CFG_BLEND, 40'd255);
    write_reg(3'd6, 40'hFFFFFFFFFF);
    write_reg(3'd7, 40'h0);
    run_pixels(10);
    write_reg(CFG_COUNT, 40'd0);
    write_reg(CFG_BLEND, 40'd511);
    run_pixels(10);

    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 49; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 49; end
        default: begin send_idle_pct = 21; stall_pct = 21; end
      endcase
      random_gradient();
      run_pixels(58);
    end

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
